@@ rtl/chc_pkg.sv @@
`timescale 1ns / 1ps
// shared constants of the cell coordinate hash table
// no dependencies; every other file refers to it by scoped names
package chc_pkg;

	// request codes
	localparam int FUNC_W = 2;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

	// result status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// port widths fixed by the interface
	localparam int IN_COORD_W  = 16;
	localparam int SLOT_W      = 12;
	localparam int NUM_CELLS_W = 13;
	localparam int HASH_W      = 32;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	// register map, index is paddr[3:2]
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_NUM_CELLS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MULT_X    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MULT_Y    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MULT_Z    = 2'd3;

	// register reset values
	localparam logic [NUM_CELLS_W-1:0] NUM_CELLS_RST = 13'd4096;
	localparam logic [HASH_W-1:0]      MULT_X_RST    = 32'd73856093;
	localparam logic [HASH_W-1:0]      MULT_Y_RST    = 32'd19349663;
	localparam logic [HASH_W-1:0]      MULT_Z_RST    = 32'd83492791;

	// remainder unit: dividend bits retired per cycle
	localparam int DIV_BITS  = 4;
	localparam int DIV_ITERS = HASH_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	// request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

endpackage

@@ rtl/chc_div.sv @@
`timescale 1ns / 1ps
// two-lane remainder unit: reduces two signed 32-bit hashes modulo the slot count
// uses chc_pkg for widths and the bits-per-cycle constant
module chc_div #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] n,
	input  logic [chc_pkg::HASH_W-1:0]    h_a,
	input  logic [chc_pkg::HASH_W-1:0]    h_b,
	output logic                          done,
	output logic [$clog2(TABLE_DEPTH)-1:0] r_a,
	output logic [$clog2(TABLE_DEPTH)-1:0] r_b
);

	localparam int A_W = $clog2(TABLE_DEPTH);
	localparam int N_W = $clog2(TABLE_DEPTH + 1);
	localparam int HW  = chc_pkg::HASH_W;
	localparam int DB  = chc_pkg::DIV_BITS;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_FIX  = 2'd2;

	logic [1:0]                     state_q;
	logic [chc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [HW-1:0]                  mag_a_q, mag_b_q;
	logic                           neg_a_q, neg_b_q;
	logic [N_W-1:0]                 rem_a_q, rem_b_q;
	logic [N_W-1:0]                 rem_a_nx, rem_b_nx;
	logic                           done_q;
	logic [A_W-1:0]                 r_a_q, r_b_q;

	// restoring remainder over DB dividend bits
	function automatic logic [N_W-1:0] rem_step(input logic [N_W-1:0] r,
		input logic [DB-1:0] bits, input logic [N_W-1:0] d);
		logic [N_W:0]   t;
		logic [N_W-1:0] acc;
		acc = r;
		for (int k = DB - 1; k >= 0; k--) begin
			t = {acc, bits[k]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
			end
			acc = t[N_W-1:0];
		end
		return acc;
	endfunction

	// negative hash: a nonzero remainder folds back to n - r
	function automatic logic [A_W-1:0] fold(input logic neg, input logic [N_W-1:0] r,
		input logic [N_W-1:0] d);
		logic [N_W-1:0] v;
		v = (neg && (r != '0)) ? (d - r) : r;
		return A_W'(v);
	endfunction

	// one step of both lanes
	always_comb begin
		rem_a_nx = rem_step(rem_a_q, mag_a_q[HW-1 -: DB], n);
		rem_b_nx = rem_step(rem_b_q, mag_b_q[HW-1 -: DB], n);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= '0;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == chc_pkg::DIV_CNT_W'(chc_pkg::DIV_ITERS - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					state_q <= D_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// datapath: magnitude load, shift and remainder accumulation
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			neg_a_q <= h_a[HW-1];
			neg_b_q <= h_b[HW-1];
			mag_a_q <= h_a[HW-1] ? (~h_a + HW'(1)) : h_a;
			mag_b_q <= h_b[HW-1] ? (~h_b + HW'(1)) : h_b;
			rem_a_q <= '0;
			rem_b_q <= '0;
		end else if (state_q == D_RUN) begin
			mag_a_q <= {mag_a_q[HW-DB-1:0], {DB{1'b0}}};
			mag_b_q <= {mag_b_q[HW-DB-1:0], {DB{1'b0}}};
			rem_a_q <= rem_a_nx;
			rem_b_q <= rem_b_nx;
		end else if (state_q == D_FIX) begin
			r_a_q <= fold(neg_a_q, rem_a_q, n);
			r_b_q <= fold(neg_b_q, rem_b_q, n);
		end
	end

	assign done = done_q;
	assign r_a  = r_a_q;
	assign r_b  = r_b_q;

	// a result never shows up without a finished run
	a_done_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == D_FIX)
		else $error("remainder done without fix step");

endmodule

@@ rtl/chc_fifo.sv @@
`timescale 1ns / 1ps
// short request queue between the hashing front and the table back
// uses chc_pkg for depth and pointer width
module chc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	localparam int PW = chc_pkg::QUEUE_PTR_W;

	logic [W-1:0]  ent_q [chc_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = ent_q[rd_ptr_q];
	assign full     = (cnt_q == (PW+1)'(chc_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request queue underflow");

endmodule

@@ rtl/chc_front.sv @@
`timescale 1ns / 1ps
// front part: takes requests, classifies them, computes both hash slots for insert and lookup
// uses chc_pkg and instantiates chc_div
module chc_front #(
	parameter int TABLE_DEPTH = 4096,
	parameter int COORD_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   hold,
	output logic                                   busy,
	input  logic [chc_pkg::FUNC_W-1:0]             func,
	input  logic signed [chc_pkg::IN_COORD_W-1:0]  cell_x,
	input  logic signed [chc_pkg::IN_COORD_W-1:0]  cell_y,
	input  logic signed [chc_pkg::IN_COORD_W-1:0]  cell_z,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]       n_eff,
	input  logic [chc_pkg::HASH_W-1:0]             mult_x,
	input  logic [chc_pkg::HASH_W-1:0]             mult_y,
	input  logic [chc_pkg::HASH_W-1:0]             mult_z,
	input  logic                                   q_full,
	output logic                                   q_push,
	output logic [chc_pkg::FUNC_W+3*COORD_BITS+2*$clog2(TABLE_DEPTH)-1:0] q_data
);

	localparam int A_W = $clog2(TABLE_DEPTH);
	localparam int CB  = COORD_BITS;
	localparam int HW  = chc_pkg::HASH_W;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_MUL   = 3'd1;
	localparam logic [2:0] F_SUM   = 3'd2;
	localparam logic [2:0] F_START = 3'd3;
	localparam logic [2:0] F_WAIT  = 3'd4;
	localparam logic [2:0] F_PUSH  = 3'd5;

	typedef struct packed {
		logic [chc_pkg::FUNC_W-1:0] func;
		logic [CB-1:0]              cx;
		logic [CB-1:0]              cy;
		logic [CB-1:0]              cz;
		logic [A_W-1:0]             idx_a;
		logic [A_W-1:0]             idx_b;
	} qent_t;

	logic [2:0]                 state_q;
	logic                       accept;
	logic [chc_pkg::FUNC_W-1:0] func_q;
	logic [CB-1:0]              cx_q, cy_q, cz_q;
	logic [HW-1:0]              px_q, py_q, pz_q;
	logic [HW-1:0]              hs_q, hx_q;
	logic [A_W-1:0]             idx_a_q, idx_b_q;
	logic                       div_done;
	logic [A_W-1:0]             div_r_a, div_r_b;
	qent_t                      ent;

	function automatic logic [HW-1:0] sext_coord(input logic [CB-1:0] c);
		return {{(HW-CB){c[CB-1]}}, c};
	endfunction

	assign busy   = (state_q != F_IDLE) || hold;
	assign accept = start && !busy;
	assign q_push = (state_q == F_PUSH) && !q_full;

	// request sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (func == chc_pkg::FUNC_INSERT || func == chc_pkg::FUNC_LOOKUP) begin
							state_q <= F_MUL;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_MUL:   state_q <= F_SUM;
				F_SUM:   state_q <= F_START;
				F_START: state_q <= F_WAIT;
				F_WAIT: begin
					if (div_done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// request capture, products, hash words and slots
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			cx_q   <= CB'($unsigned(cell_x));
			cy_q   <= CB'($unsigned(cell_y));
			cz_q   <= CB'($unsigned(cell_z));
		end
		if (state_q == F_MUL) begin
			px_q <= mult_x * sext_coord(cx_q);
			py_q <= mult_y * sext_coord(cy_q);
			pz_q <= mult_z * sext_coord(cz_q);
		end
		if (state_q == F_SUM) begin
			hs_q <= px_q + py_q + pz_q;
			hx_q <= px_q ^ py_q ^ pz_q;
		end
		if (state_q == F_WAIT && div_done) begin
			idx_a_q <= div_r_a;
			idx_b_q <= div_r_b;
		end
	end

	chc_div #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == F_START),
		.n      (n_eff),
		.h_a    (hs_q),
		.h_b    (hx_q),
		.done   (div_done),
		.r_a    (div_r_a),
		.r_b    (div_r_b)
	);

	// queue entry
	always_comb begin
		ent.func  = func_q;
		ent.cx    = cx_q;
		ent.cy    = cy_q;
		ent.cz    = cz_q;
		ent.idx_a = idx_a_q;
		ent.idx_b = idx_b_q;
	end
	assign q_data = ent;

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == F_WAIT)
		else $error("hash slots ready while front not waiting");

endmodule

@@ rtl/chc_back.sv @@
`timescale 1ns / 1ps
// back part: probes the slot memory, inserts, clears, and drives the results
// uses chc_pkg for codes and widths
module chc_back #(
	parameter int TABLE_DEPTH = 4096,
	parameter int COORD_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]    n_eff,
	input  logic                                q_empty,
	input  logic [chc_pkg::FUNC_W+3*COORD_BITS+2*$clog2(TABLE_DEPTH)-1:0] q_data,
	output logic                                q_pop,
	output logic                                init_busy,
	output logic                                done,
	output logic [chc_pkg::SLOT_W-1:0]          slot,
	output logic [chc_pkg::STATUS_W-1:0]        status
);

	localparam int A_W = $clog2(TABLE_DEPTH);
	localparam int N_W = $clog2(TABLE_DEPTH + 1);
	localparam int CB  = COORD_BITS;
	localparam int KW  = 3 * CB;
	localparam int MW  = KW + 1;

	localparam logic [1:0] B_SWEEP = 2'd0;
	localparam logic [1:0] B_IDLE  = 2'd1;
	localparam logic [1:0] B_READ  = 2'd2;
	localparam logic [1:0] B_CHECK = 2'd3;

	typedef struct packed {
		logic [chc_pkg::FUNC_W-1:0] func;
		logic [CB-1:0]              cx;
		logic [CB-1:0]              cy;
		logic [CB-1:0]              cz;
		logic [A_W-1:0]             idx_a;
		logic [A_W-1:0]             idx_b;
	} qent_t;

	qent_t                        head;
	logic [1:0]                   state_q;
	logic [A_W-1:0]               probe_q;
	logic                         probing_q;
	logic [N_W-1:0]               left_q;
	logic [chc_pkg::FUNC_W-1:0]   func_q;
	logic [KW-1:0]                key_q;
	logic [A_W-1:0]               idx_b_q;
	logic                         clr_pend_q;
	logic                         done_q;
	logic [chc_pkg::SLOT_W-1:0]   slot_q;
	logic [chc_pkg::STATUS_W-1:0] status_q;
	logic [MW-1:0]                rd_q;
	logic [MW-1:0]                slot_mem [TABLE_DEPTH];
	logic                         rd_empty, rd_hit, is_ins;
	logic [A_W:0]                 probe_inc;
	logic [A_W-1:0]               probe_wrap;
	logic                         mem_we;
	logic [MW-1:0]                mem_wdata;

	assign head = q_data;

	// slot word decode and linear probe step
	assign rd_empty   = !rd_q[KW];
	assign rd_hit     = rd_q[KW] && (rd_q[KW-1:0] == key_q);
	assign is_ins     = (func_q == chc_pkg::FUNC_INSERT);
	assign probe_inc  = {1'b0, probe_q} + (A_W+1)'(1);
	assign probe_wrap = (probe_inc >= (A_W+1)'(n_eff)) ? '0 : probe_inc[A_W-1:0];

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign init_busy = (state_q == B_SWEEP) && !clr_pend_q;

	// memory write: sweep or insert into an empty slot
	assign mem_we    = (state_q == B_SWEEP) ||
	                   ((state_q == B_CHECK) && rd_empty && is_ins);
	assign mem_wdata = (state_q == B_SWEEP) ? '0 : {1'b1, key_q};

	// probe sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_SWEEP;
			probe_q    <= '0;
			probing_q  <= 1'b0;
			left_q     <= '0;
			func_q     <= chc_pkg::FUNC_NOP;
			key_q      <= '0;
			idx_b_q    <= '0;
			clr_pend_q <= 1'b0;
			done_q     <= 1'b0;
			slot_q     <= '0;
			status_q   <= chc_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_SWEEP: begin
					if (probe_q == A_W'(TABLE_DEPTH - 1)) begin
						state_q    <= B_IDLE;
						clr_pend_q <= 1'b0;
						if (clr_pend_q) begin
							done_q   <= 1'b1;
							slot_q   <= '0;
							status_q <= chc_pkg::ST_OK;
						end
					end else begin
						probe_q <= probe_q + 1'b1;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						func_q  <= head.func;
						key_q   <= {head.cz, head.cy, head.cx};
						idx_b_q <= head.idx_b;
						unique case (head.func)
							chc_pkg::FUNC_CLEAR: begin
								state_q    <= B_SWEEP;
								probe_q    <= '0;
								clr_pend_q <= 1'b1;
							end
							chc_pkg::FUNC_INSERT, chc_pkg::FUNC_LOOKUP: begin
								state_q   <= B_READ;
								probe_q   <= head.idx_a;
								probing_q <= 1'b0;
							end
							default: begin
								// unused code: empty result, table untouched
								done_q   <= 1'b1;
								slot_q   <= '0;
								status_q <= chc_pkg::ST_OK;
							end
						endcase
					end
				end
				B_READ: state_q <= B_CHECK;
				B_CHECK: begin
					priority if (rd_empty) begin
						state_q <= B_IDLE;
						done_q  <= 1'b1;
						if (is_ins) begin
							slot_q   <= chc_pkg::SLOT_W'(probe_q);
							status_q <= chc_pkg::ST_OK;
						end else begin
							slot_q   <= '0;
							status_q <= chc_pkg::ST_NOT_FOUND;
						end
					end else if (rd_hit) begin
						state_q  <= B_IDLE;
						done_q   <= 1'b1;
						slot_q   <= chc_pkg::SLOT_W'(probe_q);
						status_q <= chc_pkg::ST_OK;
					end else if (!probing_q) begin
						// first slot taken by another cell: go to the second hash
						state_q   <= B_READ;
						probe_q   <= idx_b_q;
						probing_q <= 1'b1;
						left_q    <= n_eff - 1'b1;
					end else if (left_q == '0) begin
						state_q  <= B_IDLE;
						done_q   <= 1'b1;
						slot_q   <= '0;
						status_q <= chc_pkg::ST_FULL;
					end else begin
						state_q <= B_READ;
						left_q  <= left_q - 1'b1;
						probe_q <= probe_wrap;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// slot memory, at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[probe_q] <= mem_wdata;
		end
		if (state_q == B_READ) begin
			rd_q <= slot_mem[probe_q];
		end
	end

	assign done   = done_q;
	assign slot   = slot_q;
	assign status = status_q;

	a_slot_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != chc_pkg::ST_OK) |-> slot_q == '0)
		else $error("nonzero slot on a failed request");

	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CHECK |-> $past(state_q) == B_READ)
		else $error("slot checked without a memory read");

endmodule

@@ rtl/cell_coordinate_hash_table.sv @@
`timescale 1ns / 1ps
// top level of the cell coordinate hash table: registers, front, queue, back
// uses chc_pkg, chc_front, chc_fifo and chc_back
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  request   | start, busy, func, cell_x/y/z           | taken when start & !busy
//  result    | done, slot, status                      | done high one cycle, no stall
//  registers | psel, penable, pwrite, paddr, pwdata,   | apb write on access phase,
//            | prdata, pready                          | pready tied high
//
// insert and lookup: the front forms the hash words, then the remainder unit retires
// four hash bits per cycle; the back then reads and checks each probed slot in turn.
// clear and the unused code skip the hashing; a clear sweeps all TABLE_DEPTH slots
// of the slot memory. after reset busy stays high while the memory is swept empty.
// results are never held off by the receiver.
module cell_coordinate_hash_table #(
	parameter int TABLE_DEPTH = 4096,
	parameter int COORD_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [chc_pkg::FUNC_W-1:0]             func,
	input  logic signed [chc_pkg::IN_COORD_W-1:0]  cell_x,
	input  logic signed [chc_pkg::IN_COORD_W-1:0]  cell_y,
	input  logic signed [chc_pkg::IN_COORD_W-1:0]  cell_z,
	output logic                                   done,
	output logic [chc_pkg::SLOT_W-1:0]             slot,
	output logic [chc_pkg::STATUS_W-1:0]           status,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [chc_pkg::PADDR_W-1:0]            paddr,
	input  logic [chc_pkg::PDATA_W-1:0]            pwdata,
	output logic [chc_pkg::PDATA_W-1:0]            prdata,
	output logic                                   pready
);

	localparam int A_W = $clog2(TABLE_DEPTH);
	localparam int N_W = $clog2(TABLE_DEPTH + 1);
	localparam int QW  = chc_pkg::FUNC_W + 3 * COORD_BITS + 2 * A_W;

	logic [chc_pkg::NUM_CELLS_W-1:0] num_cells_q;
	logic [chc_pkg::HASH_W-1:0]      mult_x_q, mult_y_q, mult_z_q;
	logic [chc_pkg::REG_IDX_W-1:0]   reg_idx;
	logic                            reg_wr;
	logic [N_W-1:0]                  n_eff;
	logic                            init_busy;
	logic                            q_push, q_pop, q_full, q_empty;
	logic [QW-1:0]                   q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[chc_pkg::PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cells_q <= chc_pkg::NUM_CELLS_RST;
			mult_x_q    <= chc_pkg::MULT_X_RST;
			mult_y_q    <= chc_pkg::MULT_Y_RST;
			mult_z_q    <= chc_pkg::MULT_Z_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				chc_pkg::REG_NUM_CELLS: num_cells_q <= chc_pkg::NUM_CELLS_W'(pwdata);
				chc_pkg::REG_MULT_X:    mult_x_q    <= pwdata;
				chc_pkg::REG_MULT_Y:    mult_y_q    <= pwdata;
				chc_pkg::REG_MULT_Z:    mult_z_q    <= pwdata;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			chc_pkg::REG_NUM_CELLS: prdata = chc_pkg::PDATA_W'(num_cells_q);
			chc_pkg::REG_MULT_X:    prdata = mult_x_q;
			chc_pkg::REG_MULT_Y:    prdata = mult_y_q;
			chc_pkg::REG_MULT_Z:    prdata = mult_z_q;
		endcase
	end

	// slot count in use, clamped to one and to the table depth
	always_comb begin
		priority if (num_cells_q == '0) begin
			n_eff = N_W'(1);
		end else if (32'(num_cells_q) > 32'(TABLE_DEPTH)) begin
			n_eff = N_W'(TABLE_DEPTH);
		end else begin
			n_eff = N_W'(num_cells_q);
		end
	end

	chc_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (init_busy),
		.busy   (busy),
		.func   (func),
		.cell_x (cell_x),
		.cell_y (cell_y),
		.cell_z (cell_z),
		.n_eff  (n_eff),
		.mult_x (mult_x_q),
		.mult_y (mult_y_q),
		.mult_z (mult_z_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	chc_fifo #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	chc_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.done      (done),
		.slot      (slot),
		.status    (status)
	);

endmodule
